@@ rtl/core/ccwd_pkg.sv @@
// Shared types and constants for the CRC-checked word deframer.
// Holds the request payload structs, register indexes and reset values.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package ccwd_pkg;

  localparam int unsigned MAX_WORDS_DEFAULT = 8;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned WORD_W   = 16;
  localparam int unsigned INDEX_W  = 3;
  localparam int unsigned PHASE_W  = 2;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [BYTE_W-1:0] POLY_RESET  = 8'h31;
  localparam logic [BYTE_W-1:0] START_RESET = 8'hFF;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_CRC_POLYNOMIAL = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CRC_START      = 1'd1;

  // Position inside the current byte triple.
  localparam logic [PHASE_W-1:0] PHASE_MSB = 2'd0;
  localparam logic [PHASE_W-1:0] PHASE_LSB = 2'd1;
  localparam logic [PHASE_W-1:0] PHASE_CRC = 2'd2;

  typedef struct packed {
    logic [BYTE_W-1:0] rx_byte;
    logic              frame_end;
  } in_item_t;

  typedef struct packed {
    logic [WORD_W-1:0]  word_value;
    logic               word_crc_ok;
    logic [INDEX_W-1:0] word_index;
    logic               frame_done;
    logic               frame_ok;
    logic               frame_incomplete;
  } out_item_t;

endpackage

`default_nettype wire

@@ rtl/core/crc_checked_word_deframer.sv @@
// A byte passes the input register and then the result register; out_stall can hold a
// byte in the input register. One byte per cycle while in_stall is low; the single-byte
// CRC update sits between the input register and the running CRC register. A result held
// by out_stall stalls the input only when the next byte also carries a result.
// Reset (rst, synchronous): empty pipeline, frame state cleared, polynomial 0x31,
// start value 0xFF. Depends on ccwd_pkg and ccwd_crc8.
`timescale 1ns / 1ps
`default_nettype none

module crc_checked_word_deframer
  import ccwd_pkg::*;
#(
  parameter int unsigned MAX_WORDS = MAX_WORDS_DEFAULT
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_item_t              in_item,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_item_t                  out_item,
  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int unsigned CAP_RAW = (MAX_WORDS >= 1) ? MAX_WORDS - 1 : 0;
  localparam logic [INDEX_W-1:0] INDEX_CAP = INDEX_W'((CAP_RAW > 7) ? 7 : CAP_RAW);

  logic [BYTE_W-1:0] crc_polynomial;
  logic [BYTE_W-1:0] crc_start;

  // Input register.
  logic     s1_valid;
  in_item_t s1_item;

  // Frame state.
  logic [PHASE_W-1:0] byte_phase, byte_phase_next;
  logic [BYTE_W-1:0]  high_byte, high_byte_next;
  logic [BYTE_W-1:0]  low_byte, low_byte_next;
  logic [BYTE_W-1:0]  running_crc, running_crc_next;
  logic               frame_error, frame_error_next;
  logic [INDEX_W-1:0] word_count, word_count_next;

  logic              has_result;
  out_item_t         result;
  logic [BYTE_W-1:0] crc_seed;
  logic [BYTE_W-1:0] crc_new;
  logic              out_free;
  logic              s1_adv;
  logic              s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_polynomial <= POLY_RESET;
      crc_start      <= START_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_CRC_POLYNOMIAL: crc_polynomial <= cfg_data;
        REG_CRC_START:      crc_start      <= cfg_data;
        default: ;
      endcase
    end
  end

  assign crc_seed = (byte_phase == PHASE_LSB) ? running_crc : crc_start;

  ccwd_crc8 u_crc (
    .crc_in  (crc_seed),
    .data    (s1_item.rx_byte),
    .poly    (crc_polynomial),
    .crc_out (crc_new)
  );

  always_comb begin
    logic ok;
    logic close;
    ok                = (s1_item.rx_byte == running_crc);
    close             = 1'b0;
    has_result        = 1'b0;
    result            = '0;
    result.word_index = word_count;
    byte_phase_next   = byte_phase;
    high_byte_next    = high_byte;
    low_byte_next     = low_byte;
    running_crc_next  = running_crc;
    frame_error_next  = frame_error;
    word_count_next   = word_count;

    unique case (byte_phase)
      PHASE_CRC: begin
        has_result         = 1'b1;
        result.word_value  = ok ? {high_byte, low_byte} : '0;
        result.word_crc_ok = ok;
        result.frame_done  = s1_item.frame_end;
        result.frame_ok    = s1_item.frame_end && !frame_error && ok;
        frame_error_next   = frame_error || !ok;
        byte_phase_next    = PHASE_MSB;
        running_crc_next   = crc_start;
        if (word_count < INDEX_CAP) begin
          word_count_next = word_count + INDEX_W'(1);
        end
        close = s1_item.frame_end;
      end
      PHASE_LSB: begin
        low_byte_next    = s1_item.rx_byte;
        running_crc_next = crc_new;
        byte_phase_next  = PHASE_CRC;
      end
      default: begin
        // The unused phase code behaves as the MSB phase.
        high_byte_next   = s1_item.rx_byte;
        running_crc_next = crc_new;
        byte_phase_next  = PHASE_LSB;
      end
    endcase

    if (byte_phase != PHASE_CRC && s1_item.frame_end) begin
      has_result              = 1'b1;
      result.frame_done       = 1'b1;
      result.frame_incomplete = 1'b1;
      close                   = 1'b1;
    end

    if (close) begin
      byte_phase_next  = PHASE_MSB;
      word_count_next  = '0;
      frame_error_next = 1'b0;
      running_crc_next = crc_start;
    end
  end

  // A byte without a result never waits on the output side.
  assign out_free = !out_valid || !out_stall;
  assign s1_adv   = !has_result || out_free;
  assign s1_fire  = s1_valid && s1_adv;
  assign in_stall = s1_valid && !s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      out_valid   <= 1'b0;
      byte_phase  <= PHASE_MSB;
      high_byte   <= '0;
      low_byte    <= '0;
      running_crc <= START_RESET;
      frame_error <= 1'b0;
      word_count  <= '0;
    end else begin
      if (!s1_valid || s1_adv) begin
        s1_valid <= in_valid;
        s1_item  <= in_item;
      end
      if (s1_fire) begin
        byte_phase  <= byte_phase_next;
        high_byte   <= high_byte_next;
        low_byte    <= low_byte_next;
        running_crc <= running_crc_next;
        frame_error <= frame_error_next;
        word_count  <= word_count_next;
      end
      if (out_free) begin
        out_valid <= s1_fire && has_result;
        out_item  <= result;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/ccwd_crc8.sv @@
// One-byte CRC-8 update, MSB first, with a programmable generator.
// Pure combinational; uses widths from ccwd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ccwd_crc8
  import ccwd_pkg::*;
(
  input  wire logic [BYTE_W-1:0] crc_in,
  input  wire logic [BYTE_W-1:0] data,
  input  wire logic [BYTE_W-1:0] poly,
  output logic      [BYTE_W-1:0] crc_out
);

  always_comb begin
    logic [BYTE_W-1:0] acc;
    acc = crc_in ^ data;
    for (int k = 0; k < BYTE_W; k++) begin
      if (acc[BYTE_W-1]) begin
        acc = {acc[BYTE_W-2:0], 1'b0} ^ poly;
      end else begin
        acc = {acc[BYTE_W-2:0], 1'b0};
      end
    end
    crc_out = acc;
  end

endmodule

`default_nettype wire
